>>> design/ogwc_pkg.sv
// Shared types and constants for the onset gated window capture block.
// No dependencies; the other design files but the checker use it by scoped names.
package ogwc_pkg;

	// Window length and the address and count widths that follow from it
	localparam int FFT_SIZE = 1024;
	localparam int AW = $clog2(FFT_SIZE);
	localparam int CW = AW + 1;

	// Saturation value of the gap counter
	localparam logic [16:0] SINCE_MAX = 17'h1FFFF;

	typedef enum logic [1:0] {
		FUNC_PUSH    = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_RELEASE = 2'd2,
		FUNC_NOP     = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		CFG_BODY_ONLY       = 3'd0,
		CFG_DECAY_FACTOR    = 3'd1,
		CFG_ONSET_THRESHOLD = 3'd2,
		CFG_MIN_ONSET_GAP   = 3'd3,
		CFG_BODY_DELAY      = 3'd4,
		CFG_HOP_LENGTH      = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_EVAL,
		ST_COPY,
		ST_FIN
	} state_t;

	typedef enum logic {
		SRC_RING,
		SRC_CAPTURE
	} src_t;

	// Control from the sequencer to the envelope unit
	typedef struct packed {
		logic mul_en;
		logic commit;
	} env_ctl_t;

	// Control from the sequencer to the sample stores and copy engine
	typedef struct packed {
		logic          ring_we;
		logic          cap_we;
		logic [AW-1:0] wr_addr;
		logic [15:0]   wr_data;
		logic          copy_start;
		src_t          copy_src;
		logic [AW-1:0] copy_base;
		logic [CW-1:0] fill;
		logic [AW-1:0] rd_addr;
	} store_ctl_t;

endpackage

>>> design/ogwc_env.sv
// Peak envelope with release and onset detection with a refractory gap.
// Depends on ogwc_pkg for the control struct and the gap saturation value.
module ogwc_env (
	input  logic                clk,
	input  logic                arst_n,
	input  ogwc_pkg::env_ctl_t  ctl,
	input  logic signed [15:0]  sample,
	input  logic [15:0]         decay_factor,
	input  logic [15:0]         onset_threshold,
	input  logic [15:0]         min_onset_gap,
	output logic [15:0]         envelope,
	output logic                onset_fire
);

	logic [15:0] envelope_q;
	logic        was_over_q;
	logic [16:0] since_q;
	logic [31:0] product_s1;

	logic [16:0] neg_mag;
	logic [15:0] mag;
	logic [15:0] decayed;
	logic [15:0] env_new;
	logic        over;
	logic [16:0] since_next;

	// Multiply the held envelope by the release factor
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			product_s1 <= 32'(envelope_q) * 32'(decay_factor);
		end
	end

	// Take the magnitude, hold the larger of it and the decayed level
	always_comb begin
		neg_mag    = 17'h10000 - {1'b0, sample};
		mag        = sample[15] ? neg_mag[15:0] : sample;
		decayed    = product_s1[31:16];
		env_new    = (mag > decayed) ? mag : decayed;
		over       = env_new > onset_threshold;
		onset_fire = ctl.commit && over && !was_over_q && (since_q > {1'b0, min_onset_gap});
		if (onset_fire) begin
			since_next = 17'd1;
		end else if (since_q != ogwc_pkg::SINCE_MAX) begin
			since_next = since_q + 17'd1;
		end else begin
			since_next = since_q;
		end
	end

	// Advance the envelope state on each pushed sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			envelope_q <= '0;
			was_over_q <= 1'b0;
			since_q    <= ogwc_pkg::SINCE_MAX;
		end else if (ctl.commit) begin
			envelope_q <= env_new;
			was_over_q <= over;
			since_q    <= since_next;
		end
	end

	assign envelope = envelope_q;

endmodule

>>> design/ogwc_store.sv
// Ring, capture and staged sample memories with the window copy engine.
// Depends on ogwc_pkg for the store control struct and window sizes.
module ogwc_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ogwc_pkg::store_ctl_t  ctl,
	output logic [15:0]           rd_data,
	output logic                  busy
);

	logic [15:0] ring_mem [ogwc_pkg::FFT_SIZE];
	logic [15:0] cap_mem  [ogwc_pkg::FFT_SIZE];
	logic [15:0] stg_mem  [ogwc_pkg::FFT_SIZE];

	logic                      active_q;
	logic [ogwc_pkg::AW-1:0]   cnt_q;
	ogwc_pkg::src_t            src_q;
	logic [ogwc_pkg::AW-1:0]   base_q;
	logic [ogwc_pkg::CW-1:0]   fill_q;

	logic                      wr_en_s1;
	logic [ogwc_pkg::AW-1:0]   wr_addr_s1;
	logic                      zero_s1;
	ogwc_pkg::src_t            src_s1;

	logic [15:0]               ring_rd_q;
	logic [15:0]               cap_rd_q;
	logic [15:0]               stg_rd_q;
	logic [ogwc_pkg::AW-1:0]   src_addr;
	logic [15:0]               copy_word;

	// Walk the source circularly from the window start
	assign src_addr  = base_q + cnt_q;
	assign copy_word = zero_s1 ? 16'd0 : ((src_s1 == ogwc_pkg::SRC_CAPTURE) ? cap_rd_q : ring_rd_q);

	// Write samples, read the copy source and the staged word
	always_ff @(posedge clk) begin
		if (ctl.ring_we) begin
			ring_mem[ctl.wr_addr] <= ctl.wr_data;
		end
		if (ctl.cap_we) begin
			cap_mem[ctl.wr_addr] <= ctl.wr_data;
		end
		ring_rd_q <= ring_mem[src_addr];
		cap_rd_q  <= cap_mem[src_addr];
		stg_rd_q  <= stg_mem[ctl.rd_addr];
		if (wr_en_s1) begin
			stg_mem[wr_addr_s1] <= copy_word;
		end
	end

	// Sequence one word per cycle through the copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			wr_en_s1 <= 1'b0;
		end else begin
			wr_en_s1 <= active_q;
			if (ctl.copy_start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ogwc_pkg::AW'(ogwc_pkg::FFT_SIZE - 1)) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// Latch the window description; ring entries past the fill read as zero
	always_ff @(posedge clk) begin
		if (ctl.copy_start) begin
			src_q  <= ctl.copy_src;
			base_q <= ctl.copy_base;
			fill_q <= ctl.fill;
		end
		wr_addr_s1 <= cnt_q;
		src_s1     <= src_q;
		zero_s1    <= (src_q == ogwc_pkg::SRC_RING) && ({1'b0, src_addr} >= fill_q);
	end

	assign rd_data = stg_rd_q;
	assign busy    = active_q || wr_en_s1;

endmodule

>>> design/onset_gated_window_capture_core.sv
// An accepted item runs through CALC, EVAL, COPY when a window is staged, and FIN,
// which loads the output register once it is free; only then is a new item taken.
// The copy engine moves one word per cycle through the staged memory write port.
// Reset clears control state and loads configuration defaults; the ring reads
// as zero until written through a fill count, so no clearing pass is run.
// Depends on ogwc_pkg, ogwc_env and ogwc_store.
module onset_gated_window_capture_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [15:0] sample,
	input  logic [9:0]         read_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        envelope_level,
	output logic               onset,
	output logic               block_staged,
	output logic               block_dropped,
	output logic               block_held,
	output logic signed [15:0] read_data
);

	localparam int AW = ogwc_pkg::AW;
	localparam int CW = ogwc_pkg::CW;

	ogwc_pkg::state_t     state_q, state_n;
	ogwc_pkg::env_ctl_t   env_ctl;
	ogwc_pkg::store_ctl_t st_ctl;

	// Configuration
	logic        body_only_q;
	logic [15:0] decay_factor_q;
	logic [15:0] onset_threshold_q;
	logic [15:0] min_onset_gap_q;
	logic [15:0] body_delay_q;
	logic [10:0] hop_length_q;

	// Item registers
	ogwc_pkg::func_t   func_q;
	logic signed [15:0] sample_q;
	logic [9:0]         ridx_q;

	// Capture and ring control
	logic          armed_q, armed_n;
	logic [15:0]   delay_q, delay_n;
	logic [CW-1:0] count_q, count_n;
	logic [AW-1:0] wpos_q, wpos_n;
	logic [10:0]   hop_q, hop_n;
	logic [CW-1:0] fill_q, fill_n;
	logic          held_q, held_n;

	// Result flags
	logic          onset_q, staged_q, dropped_q;
	logic [15:0]   rdata_q;
	logic          staged_n, dropped_n;
	logic [15:0]   rdata_n;

	logic          out_valid_q;
	logic [15:0]   out_env_q;
	logic          out_onset_q, out_staged_q, out_dropped_q, out_held_q;
	logic [15:0]   out_rdata_q;

	logic          eval;
	logic          out_load;
	logic          onset_fire;
	logic [15:0]   envelope;
	logic [15:0]   stg_word;
	logic          copy_busy;

	ogwc_env u_env (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (env_ctl),
		.sample          (sample_q),
		.decay_factor    (decay_factor_q),
		.onset_threshold (onset_threshold_q),
		.min_onset_gap   (min_onset_gap_q),
		.envelope        (envelope),
		.onset_fire      (onset_fire)
	);

	ogwc_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (st_ctl),
		.rd_data (stg_word),
		.busy    (copy_busy)
	);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_only_q       <= 1'b0;
			decay_factor_q    <= 16'd65506;
			onset_threshold_q <= 16'd1036;
			min_onset_gap_q   <= 16'd4410;
			body_delay_q      <= 16'd2425;
			hop_length_q      <= 11'd256;
		end else if (cfg_we) begin
			case (ogwc_pkg::cfg_idx_t'(cfg_index))
				ogwc_pkg::CFG_BODY_ONLY:       body_only_q       <= cfg_wdata[0];
				ogwc_pkg::CFG_DECAY_FACTOR:    decay_factor_q    <= cfg_wdata;
				ogwc_pkg::CFG_ONSET_THRESHOLD: onset_threshold_q <= cfg_wdata;
				ogwc_pkg::CFG_MIN_ONSET_GAP:   min_onset_gap_q   <= cfg_wdata;
				ogwc_pkg::CFG_BODY_DELAY:      body_delay_q      <= cfg_wdata;
				ogwc_pkg::CFG_HOP_LENGTH:      hop_length_q      <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ogwc_pkg::ST_IDLE: if (in_valid) state_n = ogwc_pkg::ST_CALC;
			ogwc_pkg::ST_CALC: state_n = ogwc_pkg::ST_EVAL;
			ogwc_pkg::ST_EVAL: state_n = st_ctl.copy_start ? ogwc_pkg::ST_COPY : ogwc_pkg::ST_FIN;
			ogwc_pkg::ST_COPY: if (!copy_busy) state_n = ogwc_pkg::ST_FIN;
			ogwc_pkg::ST_FIN:  if (!out_valid_q || !out_stall) state_n = ogwc_pkg::ST_IDLE;
			default:           state_n = ogwc_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall       = (state_q != ogwc_pkg::ST_IDLE);
		eval           = (state_q == ogwc_pkg::ST_EVAL);
		env_ctl.mul_en = (state_q == ogwc_pkg::ST_CALC);
		env_ctl.commit = eval && (func_q == ogwc_pkg::FUNC_PUSH);
		out_load       = (state_q == ogwc_pkg::ST_FIN) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ogwc_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_q   <= ogwc_pkg::func_t'(func);
			sample_q <= sample;
			ridx_q   <= read_index;
		end
	end

	// Resolve body capture, ring windows, reads and release for one item
	always_comb begin
		logic [11:0] hop_inc;
		logic        complete;
		armed_n   = armed_q;
		delay_n   = delay_q;
		count_n   = count_q;
		wpos_n    = wpos_q;
		hop_n     = hop_q;
		fill_n    = fill_q;
		held_n    = held_q;
		staged_n  = 1'b0;
		dropped_n = 1'b0;
		rdata_n   = 16'd0;
		complete  = 1'b0;
		hop_inc   = 12'(hop_q) + 12'd1;
		st_ctl.ring_we    = 1'b0;
		st_ctl.cap_we     = 1'b0;
		st_ctl.wr_addr    = wpos_q;
		st_ctl.wr_data    = sample_q;
		st_ctl.copy_start = 1'b0;
		st_ctl.copy_src   = ogwc_pkg::SRC_RING;
		st_ctl.copy_base  = '0;
		st_ctl.rd_addr    = AW'(ridx_q);
		case (func_q)
			ogwc_pkg::FUNC_PUSH: begin
				if (onset_fire && body_only_q && !armed_q) begin
					armed_n = 1'b1;
					delay_n = body_delay_q;
					count_n = '0;
				end
				if (body_only_q) begin
					if (armed_n) begin
						if (delay_n != 16'd0) begin
							delay_n = delay_n - 16'd1;
						end else begin
							st_ctl.cap_we  = eval;
							st_ctl.wr_addr = count_n[AW-1:0];
							count_n        = count_n + 1'b1;
							if (count_n == CW'(ogwc_pkg::FFT_SIZE)) begin
								complete        = 1'b1;
								armed_n         = 1'b0;
								count_n         = '0;
								st_ctl.copy_src = ogwc_pkg::SRC_CAPTURE;
							end
						end
					end
				end else begin
					st_ctl.ring_we = eval;
					wpos_n         = wpos_q + 1'b1;
					if (fill_q != CW'(ogwc_pkg::FFT_SIZE)) begin
						fill_n = fill_q + 1'b1;
					end
					if (hop_inc >= {1'b0, hop_length_q}) begin
						hop_n            = '0;
						complete         = 1'b1;
						st_ctl.copy_base = wpos_n;
					end else begin
						hop_n = hop_inc[10:0];
					end
				end
				if (complete) begin
					if (held_q) begin
						dropped_n = 1'b1;
					end else begin
						staged_n          = 1'b1;
						held_n            = 1'b1;
						st_ctl.copy_start = eval;
					end
				end
			end
			ogwc_pkg::FUNC_READ: begin
				if (held_q && (32'(ridx_q) < ogwc_pkg::FFT_SIZE)) begin
					rdata_n = stg_word;
				end
			end
			ogwc_pkg::FUNC_RELEASE: held_n = 1'b0;
			default: ;
		endcase
		st_ctl.fill = fill_n;
	end

	// Commit control state at evaluation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			delay_q <= '0;
			count_q <= '0;
			wpos_q  <= '0;
			hop_q   <= '0;
			fill_q  <= '0;
			held_q  <= 1'b0;
		end else if (eval) begin
			armed_q <= armed_n;
			delay_q <= delay_n;
			count_q <= count_n;
			wpos_q  <= wpos_n;
			hop_q   <= hop_n;
			fill_q  <= fill_n;
			held_q  <= held_n;
		end
	end

	// Hold result flags until the output register frees
	always_ff @(posedge clk) begin
		if (eval) begin
			onset_q   <= onset_fire;
			staged_q  <= staged_n;
			dropped_q <= dropped_n;
			rdata_q   <= rdata_n;
		end
		if (out_load) begin
			out_env_q     <= envelope;
			out_onset_q   <= onset_q;
			out_staged_q  <= staged_q;
			out_dropped_q <= dropped_q;
			out_held_q    <= held_q;
			out_rdata_q   <= rdata_q;
		end
	end

	// Present the result item, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign envelope_level = out_env_q;
	assign onset          = out_onset_q;
	assign block_staged   = out_staged_q;
	assign block_dropped  = out_dropped_q;
	assign block_held     = out_held_q;
	assign read_data      = out_rdata_q;

endmodule

>>> design/ogwc_checker.sv
// Port-level checks for the onset gated window capture core, bound to the top.
// Depends only on the top level's ports.
module ogwc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] envelope_level,
	input logic        block_staged,
	input logic        block_dropped,
	input logic        block_held
);

	// A window is either staged or dropped, never both
	a_staged_xor_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(block_staged && block_dropped))
		else $error("window both staged and dropped");

	// A staged window leaves a block held
	a_staged_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && block_staged) |-> block_held)
		else $error("staged window without held block");

	// A dropped window means a block was and still is held
	a_dropped_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && block_dropped) |-> block_held)
		else $error("dropped window without held block");

	// The core works on one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("item accepted while previous item in progress");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(envelope_level)))
		else $error("stalled result changed");

endmodule

bind onset_gated_window_capture_core ogwc_checker u_ogwc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.envelope_level (envelope_level),
	.block_staged   (block_staged),
	.block_dropped  (block_dropped),
	.block_held     (block_held)
);

>>> dv/tb_top.sv
// Self-checking bench for onset_gated_window_capture_core: envelope, onset gating,
// hop-window and body-capture staging, staged reads and release under random idling.
// Depends on ogwc_pkg and the design files under design/.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STUCK_LIMIT = 8000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [15:0] envelope;
		logic        onset;
		logic        staged;
		logic        dropped;
		logic        held;
		logic [15:0] rdata;
	} detector_result_t;

	// Tracks detector state and the results still due from the block
	class onset_predictor;
		logic        body_only;
		logic [15:0] decay;
		logic [15:0] threshold;
		logic [15:0] min_gap;
		logic [15:0] body_delay;
		logic [10:0] hop_len;

		logic [15:0] envelope;
		logic        was_over;
		logic [16:0] since_onset;
		logic        armed;
		logic [15:0] delay_left;
		logic [10:0] cap_count;
		logic [15:0] cap_store[ogwc_pkg::FFT_SIZE];
		logic [15:0] ring_store[ogwc_pkg::FFT_SIZE];
		logic [9:0]  wr_pos;
		logic [11:0] hop_count;
		logic [15:0] staged_store[ogwc_pkg::FFT_SIZE];
		logic        held;

		detector_result_t pending_results[$];
		int mismatches;
		int n_items;
		int n_pushes;
		int n_onsets;
		int n_staged;
		int n_dropped;
		int n_held_reads;

		function new();
			body_only   = 1'b0;
			decay       = 16'd65506;
			threshold   = 16'd1036;
			min_gap     = 16'd4410;
			body_delay  = 16'd2425;
			hop_len     = 11'd256;
			envelope    = '0;
			was_over    = 1'b0;
			since_onset = ogwc_pkg::SINCE_MAX;
			armed       = 1'b0;
			delay_left  = '0;
			cap_count   = '0;
			wr_pos      = '0;
			hop_count   = '0;
			held        = 1'b0;
			for (int i = 0; i < ogwc_pkg::FFT_SIZE; i++) begin
				cap_store[i]    = '0;
				ring_store[i]   = '0;
				staged_store[i] = '0;
			end
			mismatches   = 0;
			n_items      = 0;
			n_pushes     = 0;
			n_onsets     = 0;
			n_staged     = 0;
			n_dropped    = 0;
			n_held_reads = 0;
		endfunction

		function void set_reg(ogwc_pkg::cfg_idx_t idx, logic [15:0] v);
			case (idx)
				ogwc_pkg::CFG_BODY_ONLY:       body_only = v[0];
				ogwc_pkg::CFG_DECAY_FACTOR:    decay = v;
				ogwc_pkg::CFG_ONSET_THRESHOLD: threshold = v;
				ogwc_pkg::CFG_MIN_ONSET_GAP:   min_gap = v;
				ogwc_pkg::CFG_BODY_DELAY:      body_delay = v;
				ogwc_pkg::CFG_HOP_LENGTH:      hop_len = v[10:0];
				default: ;
			endcase
		endfunction

		// Copy a window oldest first unless a block is still held
		function bit stage_window(bit from_capture, logic [9:0] start);
			if (held)
				return 1'b0;
			for (int i = 0; i < ogwc_pkg::FFT_SIZE; i++)
				staged_store[i] = from_capture ? cap_store[i]
					: ring_store[10'(int'(start) + i)];
			held = 1'b1;
			return 1'b1;
		endfunction

		function void note_item(ogwc_pkg::func_t f, logic [15:0] raw, logic [9:0] ridx);
			detector_result_t r;
			logic [16:0] mag;
			logic [31:0] decayed;
			logic        over;
			r = '0;
			n_items++;
			case (f)
				ogwc_pkg::FUNC_PUSH: begin
					n_pushes++;
					// Track the peak with release
					mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
					decayed = (32'(envelope) * 32'(decay)) >> 16;
					envelope = (32'(mag) > decayed) ? mag[15:0] : decayed[15:0];
					// Accept a rising crossing only after the refractory gap
					over = envelope > threshold;
					if (over && !was_over && since_onset > {1'b0, min_gap}) begin
						since_onset = '0;
						r.onset = 1'b1;
						if (body_only && !armed) begin
							armed      = 1'b1;
							delay_left = body_delay;
							cap_count  = '0;
						end
					end
					was_over = over;
					if (since_onset != ogwc_pkg::SINCE_MAX)
						since_onset++;
					if (body_only) begin
						// Count down the delay, then fill the capture window
						if (armed) begin
							if (delay_left != 0) begin
								delay_left--;
							end else begin
								cap_store[cap_count[9:0]] = raw;
								cap_count++;
								if (cap_count >= 11'(ogwc_pkg::FFT_SIZE)) begin
									if (stage_window(1'b1, '0))
										r.staged = 1'b1;
									else
										r.dropped = 1'b1;
									armed     = 1'b0;
									cap_count = '0;
								end
							end
						end
					end else begin
						// Write the ring and stage a window every hop
						ring_store[wr_pos] = raw;
						wr_pos++;
						hop_count++;
						if (hop_count >= {1'b0, hop_len}) begin
							hop_count = '0;
							if (stage_window(1'b0, wr_pos))
								r.staged = 1'b1;
							else
								r.dropped = 1'b1;
						end
					end
				end
				ogwc_pkg::FUNC_READ: begin
					if (held) begin
						r.rdata = staged_store[ridx];
						n_held_reads++;
					end
				end
				ogwc_pkg::FUNC_RELEASE: held = 1'b0;
				default: ;
			endcase
			r.envelope = envelope;
			r.held     = held;
			n_onsets  += r.onset;
			n_staged  += r.staged;
			n_dropped += r.dropped;
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void check_result(detector_result_t got);
			detector_result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("[%0t] result with no item waiting: env %0d data %0d",
						$realtime, got.envelope, $signed(got.rdata));
				return;
			end
			want = pending_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display({"[%0t] mismatch: expected env %0d onset %0b staged %0b",
						" dropped %0b held %0b data %0d"},
						$realtime, want.envelope, want.onset, want.staged, want.dropped,
						want.held, $signed(want.rdata));
					$display({"[%0t]           got env %0d onset %0b staged %0b",
						" dropped %0b held %0b data %0d"},
						$realtime, got.envelope, got.onset, got.staged, got.dropped,
						got.held, $signed(got.rdata));
				end
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         func;
	logic signed [15:0] sample;
	logic [9:0]         read_index;
	logic               out_valid;
	logic               out_stall;
	logic [15:0]        envelope_level;
	logic               onset;
	logic               block_staged;
	logic               block_dropped;
	logic               block_held;
	logic signed [15:0] read_data;

	bit             calm;
	int             stuck_cycles = 0;
	onset_predictor predictor = new();

	onset_gated_window_capture_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.sample         (sample),
		.read_index     (read_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.envelope_level (envelope_level),
		.onset          (onset),
		.block_staged   (block_staged),
		.block_dropped  (block_dropped),
		.block_held     (block_held),
		.read_data      (read_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Count cycles in which neither side moves an item
	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
			(out_valid === 1'b1 && out_stall === 1'b0))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT)
			@(posedge clk);
		$display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// Receive results with a random stall ahead of each one
	initial begin
		int hold;
		detector_result_t got;
		out_stall = 1'b0;
		forever begin
			hold = calm ? 0 : $urandom_range(0, 12);
			if (hold > 0) begin
				@(negedge clk) out_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
				@(negedge clk) out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
			got.envelope = envelope_level;
			got.onset    = onset;
			got.staged   = block_staged;
			got.dropped  = block_dropped;
			got.held     = block_held;
			got.rdata    = read_data;
			predictor.check_result(got);
		end
	end

	task automatic write_reg(ogwc_pkg::cfg_idx_t idx, logic [15:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		predictor.set_reg(idx, v);
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	// Present one item after a random gap and hold it until taken
	task automatic send_item(ogwc_pkg::func_t f, logic [15:0] s, logic [9:0] ridx);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		func       <= f;
		sample     <= s;
		read_index <= ridx;
		do @(posedge clk); while (in_stall !== 1'b0);
		predictor.note_item(f, s, ridx);
	endtask

	// Hold off the sender until every result is back
	task automatic drain_outputs();
		@(negedge clk) in_valid <= 1'b0;
		while (predictor.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] pick_sample();
		int k;
		int v;
		k = $urandom_range(0, 99);
		if (k < 40) begin
			v = int'($urandom_range(0, 400)) - 200;
		end else if (k < 75) begin
			v = int'($urandom());
		end else if (k < 90) begin
			case ($urandom_range(0, 3))
				0: v = 32'h7FFF;
				1: v = 32'h8000;
				2: v = 32'hFFFF;
				default: v = 0;
			endcase
		end else begin
			v = int'($urandom_range(0, 6000)) - 3000;
		end
		return v[15:0];
	endfunction

	// Mostly pushes; the rest split over reads, releases and no-ops
	task automatic run_random(int n, int push_pct);
		int k;
		int rest;
		logic [9:0] ridx;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			rest = 100 - push_pct;
			ridx = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 10'd1023 : 10'd0)
				: 10'($urandom_range(0, 1023));
			if (k < push_pct)
				send_item(ogwc_pkg::FUNC_PUSH, pick_sample(), 10'($urandom()));
			else if (k < push_pct + rest / 2)
				send_item(ogwc_pkg::FUNC_READ, 16'($urandom()), ridx);
			else if (k < push_pct + (rest * 5) / 6)
				send_item(ogwc_pkg::FUNC_RELEASE, 16'($urandom()), 10'($urandom()));
			else
				send_item(ogwc_pkg::FUNC_NOP, 16'($urandom()), 10'($urandom()));
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = ogwc_pkg::CFG_BODY_ONLY;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		func       = ogwc_pkg::FUNC_NOP;
		sample     = '0;
		read_index = '0;
		calm       = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed: short hops, reads and releases around held blocks
		write_reg(ogwc_pkg::CFG_BODY_ONLY, 16'd0);
		write_reg(ogwc_pkg::CFG_DECAY_FACTOR, 16'd40000);
		write_reg(ogwc_pkg::CFG_ONSET_THRESHOLD, 16'd1000);
		write_reg(ogwc_pkg::CFG_MIN_ONSET_GAP, 16'd0);
		write_reg(ogwc_pkg::CFG_BODY_DELAY, 16'd0);
		write_reg(ogwc_pkg::CFG_HOP_LENGTH, 16'd4);
		send_item(ogwc_pkg::FUNC_READ, 16'h0000, 10'd0);
		send_item(ogwc_pkg::FUNC_READ, 16'hFFFF, 10'd1023);
		send_item(ogwc_pkg::FUNC_RELEASE, 16'h1234, 10'd17);
		send_item(ogwc_pkg::FUNC_NOP, 16'h8000, 10'd1023);
		send_item(ogwc_pkg::FUNC_PUSH, 16'h0000, 10'd0);
		send_item(ogwc_pkg::FUNC_PUSH, 16'h7FFF, 10'd0);
		send_item(ogwc_pkg::FUNC_PUSH, 16'h8000, 10'd0);
		send_item(ogwc_pkg::FUNC_PUSH, 16'hFFFF, 10'd0);
		send_item(ogwc_pkg::FUNC_PUSH, 16'h0001, 10'd0);
		send_item(ogwc_pkg::FUNC_READ, 16'h0000, 10'd0);
		send_item(ogwc_pkg::FUNC_READ, 16'h0000, 10'd1023);
		send_item(ogwc_pkg::FUNC_READ, 16'h0000, 10'd3);
		send_item(ogwc_pkg::FUNC_PUSH, 16'h0000, 10'd0);
		send_item(ogwc_pkg::FUNC_PUSH, 16'h0000, 10'd0);
		send_item(ogwc_pkg::FUNC_PUSH, 16'h0000, 10'd0);
		send_item(ogwc_pkg::FUNC_RELEASE, 16'h0000, 10'd0);
		send_item(ogwc_pkg::FUNC_READ, 16'h0000, 10'd5);
		send_item(ogwc_pkg::FUNC_PUSH, 16'h8001, 10'd0);
		send_item(ogwc_pkg::FUNC_PUSH, 16'd1000, 10'd0);
		send_item(ogwc_pkg::FUNC_PUSH, 16'h0000, 10'd0);
		send_item(ogwc_pkg::FUNC_PUSH, 16'h0000, 10'd0);
		send_item(ogwc_pkg::FUNC_READ, 16'h0000, 10'd1020);
		send_item(ogwc_pkg::FUNC_READ, 16'h0000, 10'd1023);
		send_item(ogwc_pkg::FUNC_RELEASE, 16'h0000, 10'd0);
		send_item(ogwc_pkg::FUNC_PUSH, 16'h5555, 10'd0);
		send_item(ogwc_pkg::FUNC_PUSH, 16'hAAAA, 10'd0);
		drain_outputs();

		// Window on every sample, instant release, zero threshold, no idling
		write_reg(ogwc_pkg::CFG_HOP_LENGTH, 16'd1);
		write_reg(ogwc_pkg::CFG_DECAY_FACTOR, 16'd0);
		write_reg(ogwc_pkg::CFG_ONSET_THRESHOLD, 16'd0);
		write_reg(ogwc_pkg::CFG_MIN_ONSET_GAP, 16'd3);
		calm = 1'b1;
		run_random(35, 60);
		calm = 1'b0;
		drain_outputs();

		// Zero hop, slowest release, threshold out of reach
		write_reg(ogwc_pkg::CFG_HOP_LENGTH, 16'd0);
		write_reg(ogwc_pkg::CFG_DECAY_FACTOR, 16'd65535);
		write_reg(ogwc_pkg::CFG_ONSET_THRESHOLD, 16'd32768);
		run_random(25, 60);
		drain_outputs();

		// Full-window hop: build up a count, then lower the hop below it
		write_reg(ogwc_pkg::CFG_HOP_LENGTH, 16'd1024);
		write_reg(ogwc_pkg::CFG_DECAY_FACTOR, 16'd20000);
		write_reg(ogwc_pkg::CFG_ONSET_THRESHOLD, 16'd800);
		run_random(30, 85);
		drain_outputs();
		write_reg(ogwc_pkg::CFG_HOP_LENGTH, 16'd7);
		write_reg(ogwc_pkg::CFG_MIN_ONSET_GAP, 16'd65535);
		run_random(30, 70);
		drain_outputs();

		// Body capture: force an onset, then fill the start of a window
		write_reg(ogwc_pkg::CFG_BODY_ONLY, 16'd1);
		write_reg(ogwc_pkg::CFG_MIN_ONSET_GAP, 16'd10);
		write_reg(ogwc_pkg::CFG_ONSET_THRESHOLD, 16'd500);
		write_reg(ogwc_pkg::CFG_BODY_DELAY, 16'd3);
		repeat (12) send_item(ogwc_pkg::FUNC_PUSH, 16'h0000, 10'd0);
		send_item(ogwc_pkg::FUNC_PUSH, 16'd30000, 10'd0);
		run_random(40, 92);
		drain_outputs();

		// Switch to hop windows mid-capture, then resume the capture
		write_reg(ogwc_pkg::CFG_BODY_ONLY, 16'd0);
		write_reg(ogwc_pkg::CFG_HOP_LENGTH, 16'd50);
		run_random(25, 80);
		drain_outputs();
		write_reg(ogwc_pkg::CFG_BODY_ONLY, 16'd1);
		run_random(25, 92);
		drain_outputs();

		// Longest body delay
		write_reg(ogwc_pkg::CFG_BODY_DELAY, 16'd65535);
		repeat (12) send_item(ogwc_pkg::FUNC_PUSH, 16'h0000, 10'd0);
		send_item(ogwc_pkg::FUNC_PUSH, 16'h8000, 10'd0);
		run_random(8, 80);
		drain_outputs();

		// Back to short hops, first with both sides running flat out, then with random idling
		write_reg(ogwc_pkg::CFG_BODY_ONLY, 16'd0);
		write_reg(ogwc_pkg::CFG_HOP_LENGTH, 16'd3);
		write_reg(ogwc_pkg::CFG_MIN_ONSET_GAP, 16'd0);
		calm = 1'b1;
		run_random(12, 70);
		calm = 1'b0;
		run_random(12, 70);
		drain_outputs();
		repeat (16) @(posedge clk);

		$display("Covered %0d items (%0d pushes): %0d onsets, %0d windows staged, %0d dropped,",
			predictor.n_items, predictor.n_pushes, predictor.n_onsets,
			predictor.n_staged, predictor.n_dropped);
		$display("%0d reads of a held block, %0d mismatches.",
			predictor.n_held_reads, predictor.mismatches);
		if (predictor.mismatches == 0 && predictor.outstanding() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
